FILE: sv/qla_pkg.sv
// Shared types and constants of the Q-learning agent step core.
`default_nettype none

package qla_pkg;

   typedef logic signed [23:0] q_value_type;
   typedef logic signed [25:0] mul_op_type;
   typedef logic signed [26:0] mul_res_type;
   typedef logic signed [34:0] mul_prod_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CURRD,
      ST_GAMMA,
      ST_STEP,
      ST_WRITE,
      ST_TAIL,
      ST_DONE
   } seq_state_type;

   localparam logic [1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [1:0] CSR_DISCOUNT        = 2'd1;
   localparam logic [1:0] CSR_EXPLORE_PERCENT = 2'd2;

   localparam logic [7:0] LEARNING_RATE_RESET   = 8'd26;
   localparam logic [7:0] DISCOUNT_RESET        = 8'd230;
   localparam logic [6:0] EXPLORE_PERCENT_RESET = 7'd10;

   localparam mul_prod_type ROUND_HALF = 35'sd128;
   localparam int           FRAC_BITS  = 8;

   localparam mul_res_type Q_MAX = 27'sd8388607;
   localparam mul_res_type Q_MIN = -27'sd8388608;

endpackage

`default_nettype wire

FILE: sv/qla_value_ram.sv
// Value table memory with one write port and one registered read port.
`default_nettype none

module qla_value_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [ADDR_W-1:0]         wr_addr,
   input  wire qla_pkg::q_value_type wr_data,
   input  wire  [ADDR_W-1:0]         rd_addr,
   output qla_pkg::q_value_type      rd_data
);
   import qla_pkg::*;

   q_value_type mem [DEPTH];
   q_value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/qla_mul_unit.sv
// Shared rate multiplier with registered product and round-half-up scaling by 1/256.
`default_nettype none

module qla_mul_unit (
   input  wire                      clock,
   input  wire  [7:0]               rate,
   input  wire qla_pkg::mul_op_type operand,
   output qla_pkg::mul_res_type     result
);
   import qla_pkg::*;

   mul_prod_type prod_ff;
   mul_prod_type prod_in;
   mul_prod_type rounded;

   assign prod_in = mul_prod_type'($signed({1'b0, rate})) * mul_prod_type'(operand);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign rounded = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
   assign result  = mul_res_type'(rounded);

endmodule

`default_nettype wire

FILE: sv/q_learning_agent_step_core.sv
// Q-learning agent step core: one step per start, result as a one-cycle rsp_valid strobe.
// Sequence: a scan of the observed state's row finds the best action; with an update the previous
// entry is then read, moved toward the reward plus the discounted best value by the learning rate
// and written back, and the row is scanned again when the previous state equals the observed state.
// A new start is taken only in idle, at the earliest while rsp_valid is high.
// After reset a clearing pass zeroes every table entry; busy is high meanwhile.
// The receiver cannot stall; configuration writes are taken in every cycle.
`default_nettype none

module q_learning_agent_step_core #(
   parameter int STATE_COUNT  = 4,
   parameter int ACTION_COUNT = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [1:0]               req_observed_state,
   input  wire  signed [7:0]        req_reward,
   input  wire                      req_has_previous,
   input  wire  [6:0]               req_explore_draw,
   input  wire  [1:0]               req_random_action,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_action,
   output logic                     rsp_explored,
   output qla_pkg::q_value_type     rsp_updated_value,
   output logic                     rsp_saturated,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [1:0]               csr_index,
   input  wire  [7:0]               csr_wdata
);
   import qla_pkg::*;

   localparam int TABLE_SIZE = STATE_COUNT * ACTION_COUNT;
   localparam int ST_W       = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
   localparam int AC_W       = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
   localparam int TAB_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

   seq_state_type     state_ff, state_in;
   logic [TAB_W-1:0]  clr_ff, clr_in;
   logic [AC_W-1:0]   k_ff, k_in;
   logic              pass2_ff, pass2_in;
   logic              rvalid_ff, rvalid_in;
   logic [AC_W-1:0]   rk_ff, rk_in;

   logic [ST_W-1:0]   s_ff, s_in;
   logic [TAB_W-1:0]  base_ff, base_in;
   logic signed [7:0] reward_ff, reward_in;
   logic              has_prev_ff, has_prev_in;
   logic [6:0]        draw_ff, draw_in;
   logic [AC_W-1:0]   ract_ff, ract_in;

   q_value_type       best_val_ff, best_val_in;
   logic [AC_W-1:0]   best_idx_ff, best_idx_in;
   q_value_type       cur_ff, cur_in;
   q_value_type       newq_ff, newq_in;
   logic              sat_ff, sat_in;

   logic [ST_W-1:0]   last_state_ff, last_state_in;
   logic [AC_W-1:0]   last_action_ff, last_action_in;

   logic [7:0]        lr_ff, lr_in;
   logic [7:0]        disc_ff, disc_in;
   logic [6:0]        expl_pct_ff, expl_pct_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_action_ff, rsp_action_in;
   logic              rsp_explored_ff, rsp_explored_in;
   q_value_type       rsp_value_ff, rsp_value_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic              ram_we;
   logic [TAB_W-1:0]  ram_waddr;
   q_value_type       ram_wdata;
   logic [TAB_W-1:0]  ram_raddr;
   q_value_type       ram_rdata;

   logic [7:0]        mul_rate;
   mul_op_type        mul_operand;
   mul_res_type       mul_result;

   logic [1:0]        obs_red;
   logic [1:0]        ract_red;
   logic [TAB_W-1:0]  last_idx;
   mul_op_type        target;
   mul_op_type        diff;
   mul_res_type       newq_wide;
   logic              explore;
   logic [AC_W-1:0]   act;

   qla_value_ram #(
      .DEPTH  (TABLE_SIZE),
      .ADDR_W (TAB_W)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   qla_mul_unit u_mul_unit (
      .clock   (clock),
      .rate    (mul_rate),
      .operand (mul_operand),
      .result  (mul_result)
   );

   assign obs_red  = (32'(req_observed_state) >= STATE_COUNT) ?
                     2'(32'(req_observed_state) - STATE_COUNT) : req_observed_state;
   assign ract_red = (32'(req_random_action) >= ACTION_COUNT) ?
                     2'(32'(req_random_action) - ACTION_COUNT) : req_random_action;
   assign last_idx = TAB_W'(32'(last_state_ff) * ACTION_COUNT) + TAB_W'(last_action_ff);

   assign mul_rate    = (state_ff == ST_STEP) ? lr_ff : disc_ff;
   assign mul_operand = (state_ff == ST_STEP) ? diff : mul_op_type'(best_val_ff);

   assign target    = (mul_op_type'(reward_ff) <<< FRAC_BITS) + mul_op_type'(mul_result);
   assign diff      = target - mul_op_type'(cur_ff);
   assign newq_wide = mul_res_type'(cur_ff) + mul_result;

   assign explore = (draw_ff < expl_pct_ff);
   assign act     = explore ? ract_ff : best_idx_ff;

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      k_in            = k_ff;
      pass2_in        = pass2_ff;
      rvalid_in       = (state_ff == ST_SCAN);
      rk_in           = k_ff;
      s_in            = s_ff;
      base_in         = base_ff;
      reward_in       = reward_ff;
      has_prev_in     = has_prev_ff;
      draw_in         = draw_ff;
      ract_in         = ract_ff;
      best_val_in     = best_val_ff;
      best_idx_in     = best_idx_ff;
      cur_in          = cur_ff;
      newq_in         = newq_ff;
      sat_in          = sat_ff;
      last_state_in   = last_state_ff;
      last_action_in  = last_action_ff;
      lr_in           = lr_ff;
      disc_in         = disc_ff;
      expl_pct_in     = expl_pct_ff;
      rsp_valid_in    = 1'b0;
      rsp_action_in   = rsp_action_ff;
      rsp_explored_in = rsp_explored_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_sat_in      = rsp_sat_ff;
      ram_we          = 1'b0;
      ram_waddr       = last_idx;
      ram_wdata       = newq_wide[23:0];
      ram_raddr       = base_ff + TAB_W'(k_ff);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:   lr_in       = csr_wdata;
            CSR_DISCOUNT:        disc_in     = csr_wdata;
            CSR_EXPLORE_PERCENT: expl_pct_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      if (rvalid_ff) begin
         if (rk_ff == '0 || ram_rdata > best_val_ff) begin
            best_val_in = ram_rdata;
            best_idx_in = rk_ff;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + TAB_W'(1);
            if (clr_ff == TAB_W'(TABLE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               s_in        = ST_W'(obs_red);
               base_in     = TAB_W'(32'(ST_W'(obs_red)) * ACTION_COUNT);
               reward_in   = req_reward;
               has_prev_in = req_has_previous;
               draw_in     = req_explore_draw;
               ract_in     = AC_W'(ract_red);
               newq_in     = '0;
               sat_in      = 1'b0;
               k_in        = '0;
               pass2_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            k_in = k_ff + AC_W'(1);
            if (k_ff == AC_W'(ACTION_COUNT - 1)) begin
               state_in = (pass2_ff || !has_prev_ff) ? ST_TAIL : ST_CURRD;
            end
         end
         ST_CURRD: begin
            ram_raddr = last_idx;
            state_in  = ST_GAMMA;
         end
         ST_GAMMA: begin
            cur_in   = ram_rdata;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            if (newq_wide > Q_MAX) begin
               ram_wdata = Q_MAX[23:0];
               sat_in    = 1'b1;
            end else if (newq_wide < Q_MIN) begin
               ram_wdata = Q_MIN[23:0];
               sat_in    = 1'b1;
            end else begin
               sat_in    = 1'b0;
            end
            newq_in = ram_wdata;
            if (last_state_ff == s_ff) begin
               k_in     = '0;
               pass2_in = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            last_state_in   = s_ff;
            last_action_in  = act;
            rsp_valid_in    = 1'b1;
            rsp_action_in   = 2'(act);
            rsp_explored_in = explore;
            rsp_value_in    = newq_ff;
            rsp_sat_in      = sat_ff;
            state_in        = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         k_ff           <= '0;
         pass2_ff       <= 1'b0;
         rvalid_ff      <= 1'b0;
         last_state_ff  <= '0;
         last_action_ff <= '0;
         lr_ff          <= LEARNING_RATE_RESET;
         disc_ff        <= DISCOUNT_RESET;
         expl_pct_ff    <= EXPLORE_PERCENT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         k_ff           <= k_in;
         pass2_ff       <= pass2_in;
         rvalid_ff      <= rvalid_in;
         last_state_ff  <= last_state_in;
         last_action_ff <= last_action_in;
         lr_ff          <= lr_in;
         disc_ff        <= disc_in;
         expl_pct_ff    <= expl_pct_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rk_ff           <= rk_in;
      s_ff            <= s_in;
      base_ff         <= base_in;
      reward_ff       <= reward_in;
      has_prev_ff     <= has_prev_in;
      draw_ff         <= draw_in;
      ract_ff         <= ract_in;
      best_val_ff     <= best_val_in;
      best_idx_ff     <= best_idx_in;
      cur_ff          <= cur_in;
      newq_ff         <= newq_in;
      sat_ff          <= sat_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_explored_ff <= rsp_explored_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_sat_ff      <= rsp_sat_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_explored      = rsp_explored_ff;
   assign rsp_updated_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

`default_nettype wire
